// ===== hw/rtl/xkrc_pkg.sv =====
// shared types and constants of the xor keystream rekey cipher
`timescale 1ns / 1ps

package xkrc_pkg;

  // width of the key length register and of the key position
  localparam int LENW = 6;
  // number of 64-bit initial key registers
  localparam int NUM_KEY_REGS = 4;
  // width of the configuration register index
  localparam int CFG_IDXW = 3;
  // residues are taken modulo 2^MOD_BITS - 1
  localparam int MOD_BITS = 7;
  localparam logic [MOD_BITS-1:0] KEY_MODULUS = '1;
  // offset added to each key byte before it enters the running product
  localparam logic signed [9:0] PROD_OFFSET = 10'sd2;

  // configuration register indexes
  typedef enum logic [CFG_IDXW-1:0] {
    CFG_KEY_LEN = 3'd0,
    CFG_KEY0    = 3'd1,
    CFG_KEY1    = 3'd2,
    CFG_KEY2    = 3'd3,
    CFG_KEY3    = 3'd4
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_RK_LOAD,
    ST_RK_BASE,
    ST_RK_BASEW,
    ST_RK_MUL,
    ST_RK_ACCW,
    ST_RK_SQ,
    ST_RK_SQW
  } st_e;

  // request into the modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } mod_req_t;

  // response from the modulo unit
  typedef struct packed {
    logic              done;
    logic signed [7:0] rem;
  } mod_rsp_t;

endpackage

// ===== hw/rtl/xor_keystream_rekey_cipher.sv =====
// top level of the xor keystream cipher with periodic rekeying
`timescale 1ns / 1ps

// Each request XORs its data byte with the working key byte at the key
// position and moves the position on. A request that does not trigger a
// rekey is taken and its result is registered at the same edge, so such
// bytes flow at one per cycle as long as the output register is free.
// When the position reaches the key length, the key is rekeyed first: a
// sequencer drives one shared 32x10 multiplier and an iterative modulo-127
// folder (one fold of seven bits per cycle). For each key byte in use it
// updates the running product; a byte that is zero or negative then becomes
// one, any other is replaced by the reduced product raised to it in up to 7
// exponent steps. After the last key byte it hands out the byte held over
// the rekey. Input stall stays high while rekeying. A configuration write
// to a key or key length register reloads the whole working key from the
// key registers and leaves the key position unchanged.

module xor_keystream_rekey_cipher #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [xkrc_pkg::CFG_IDXW-1:0]   cfg_idx_i,
  input  logic [63:0]                     cfg_wdata_i,
  // input request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            start_file_i,
  // output request channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      cipher_byte_o
);
  import xkrc_pkg::*;

  localparam int IDXW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  st_e               state_q, state_d;
  logic [LENW-1:0]   key_len_q, key_len_d;
  logic [63:0]       kreg_q [NUM_KEY_REGS];
  logic [63:0]       kreg_d [NUM_KEY_REGS];
  logic [7:0]        wk_q [MAX_KEY_BYTES];
  logic [7:0]        wk_d [MAX_KEY_BYTES];
  logic [LENW-1:0]   pos_q, pos_d;
  logic [7:0]        data_q, data_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic [31:0]       prod_q, prod_d;
  logic [6:0]        exp_q, exp_d;
  logic signed [7:0] acc_q, acc_d;
  logic signed [7:0] sq_q, sq_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;

  logic              cfg_load;
  logic [LENW-1:0]   len_eff;
  logic [LENW-1:0]   pos_eff;
  logic              in_acc;
  logic              out_free;
  logic [IDXW-1:0]   rd_idx;
  logic [7:0]        rd_byte;
  logic signed [31:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [41:0] mul_full;
  logic              wk_we;
  logic [7:0]        wk_wval;
  logic              byte_done;
  logic [6:0]        exp_half;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  // shared modulo unit
  xkrc_mod127 u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // key length clamped to 1..MAX_KEY_BYTES
  always_comb begin
    if (key_len_q == '0) begin
      len_eff = LENW'(1);
    end else if (key_len_q > LENW'(MAX_KEY_BYTES)) begin
      len_eff = LENW'(MAX_KEY_BYTES);
    end else begin
      len_eff = key_len_q;
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_eff    = start_file_i ? '0 : pos_q;

  // working key read port
  always_comb begin
    case (state_q)
      ST_IDLE: rd_idx = pos_eff[IDXW-1:0];
      ST_EMIT: rd_idx = pos_q[IDXW-1:0];
      default: rd_idx = idx_q;
    endcase
  end
  assign rd_byte = wk_q[rd_idx];

  // shared multiplier operands
  always_comb begin
    case (state_q)
      ST_RK_LOAD: begin
        mul_a = prod_q;
        mul_b = {{2{rd_byte[7]}}, rd_byte} + PROD_OFFSET;
      end
      ST_RK_MUL: begin
        mul_a = {{24{acc_q[7]}}, acc_q};
        mul_b = {{2{sq_q[7]}}, sq_q};
      end
      default: begin
        mul_a = {{24{sq_q[7]}}, sq_q};
        mul_b = {{2{sq_q[7]}}, sq_q};
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;
  assign exp_half = exp_q >> 1;

  // configuration registers
  assign cfg_load = cfg_we_i && (cfg_idx_i <= CFG_KEY3);
  always_comb begin
    key_len_d = key_len_q;
    for (int r = 0; r < NUM_KEY_REGS; r++) begin
      kreg_d[r] = kreg_q[r];
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LEN: key_len_d = cfg_wdata_i[LENW-1:0];
        CFG_KEY0:    kreg_d[0] = cfg_wdata_i;
        CFG_KEY1:    kreg_d[1] = cfg_wdata_i;
        CFG_KEY2:    kreg_d[2] = cfg_wdata_i;
        CFG_KEY3:    kreg_d[3] = cfg_wdata_i;
        default:     key_len_d = key_len_q;
      endcase
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    data_d       = data_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    exp_d        = exp_q;
    acc_d        = acc_q;
    sq_d         = sq_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    mod_req      = '0;
    wk_we        = 1'b0;
    wk_wval      = acc_q;
    byte_done    = 1'b0;
    case (state_q)
      // take a request, answer at once unless a rekey is due
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_eff >= len_eff) begin
            data_d  = data_byte_i;
            pos_d   = '0;
            idx_d   = '0;
            prod_d  = 32'd1;
            state_d = ST_RK_LOAD;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = data_byte_i ^ rd_byte;
            pos_d       = pos_eff + LENW'(1);
          end
        end
      end
      // deliver the byte held over a rekey
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = data_q ^ rd_byte;
          pos_d       = pos_q + LENW'(1);
          state_d     = ST_IDLE;
        end
      end
      // update the running product, take the exponent
      ST_RK_LOAD: begin
        prod_d  = mul_full[31:0];
        exp_d   = rd_byte[7] ? '0 : rd_byte[6:0];
        state_d = ST_RK_BASE;
      end
      // reduce the product, or finish at once for a non-positive exponent
      ST_RK_BASE: begin
        if (exp_q == '0) begin
          wk_wval   = 8'd1;
          byte_done = 1'b1;
        end else begin
          mod_req.start = 1'b1;
          mod_req.value = prod_q;
          state_d       = ST_RK_BASEW;
        end
      end
      ST_RK_BASEW: begin
        if (mod_rsp.done) begin
          sq_d    = mod_rsp.rem;
          acc_d   = 8'sd1;
          state_d = ST_RK_MUL;
        end
      end
      // multiply the accumulator when the exponent bit is set
      ST_RK_MUL: begin
        if (exp_q[0]) begin
          mod_req.start = 1'b1;
          mod_req.value = mul_full[31:0];
          state_d       = ST_RK_ACCW;
        end else begin
          state_d = ST_RK_SQ;
        end
      end
      ST_RK_ACCW: begin
        if (mod_rsp.done) begin
          acc_d   = mod_rsp.rem;
          state_d = ST_RK_SQ;
        end
      end
      // square the base unless the exponent is used up
      ST_RK_SQ: begin
        if (exp_half == '0) begin
          byte_done = 1'b1;
        end else begin
          exp_d         = exp_half;
          mod_req.start = 1'b1;
          mod_req.value = mul_full[31:0];
          state_d       = ST_RK_SQW;
        end
      end
      ST_RK_SQW: begin
        if (mod_rsp.done) begin
          sq_d    = mod_rsp.rem;
          state_d = ST_RK_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // store the new key byte and move to the next one
    if (byte_done) begin
      wk_we = 1'b1;
      if (LENW'(idx_q) == len_eff - LENW'(1)) begin
        state_d = ST_EMIT;
      end else begin
        idx_d   = idx_q + IDXW'(1);
        state_d = ST_RK_LOAD;
      end
    end
  end

  // working key next value: full reload on configuration, else one byte
  always_comb begin
    for (int k = 0; k < MAX_KEY_BYTES; k++) begin
      wk_d[k] = wk_q[k];
    end
    if (cfg_load) begin
      for (int r = 0; r < NUM_KEY_REGS; r++) begin
        for (int j = 0; j < 8; j++) begin
          if (r * 8 + j < MAX_KEY_BYTES) begin
            wk_d[r * 8 + j] = kreg_d[r][j * 8 +: 8];
          end
        end
      end
    end else if (wk_we) begin
      wk_d[idx_q] = wk_wval;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_len_q   <= LENW'(1);
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_KEY_REGS; r++) begin
        kreg_q[r] <= '0;
      end
      for (int k = 0; k < MAX_KEY_BYTES; k++) begin
        wk_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      key_len_q   <= key_len_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      for (int r = 0; r < NUM_KEY_REGS; r++) begin
        kreg_q[r] <= kreg_d[r];
      end
      for (int k = 0; k < MAX_KEY_BYTES; k++) begin
        wk_q[k] <= wk_d[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    idx_q      <= idx_d;
    prod_q     <= prod_d;
    exp_q      <= exp_d;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = out_data_q;

endmodule

// ===== hw/rtl/xkrc_mod127.sv =====
// iterative signed truncating remainder by 127, folding seven bits per cycle
`timescale 1ns / 1ps

module xkrc_mod127 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xkrc_pkg::mod_req_t req_i,
  output xkrc_pkg::mod_rsp_t rsp_o
);
  import xkrc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [31:0]       mag_q, mag_d;
  logic signed [7:0] rem_q, rem_d;
  logic [MOD_BITS-1:0] res7;

  // final residue of a magnitude below 128
  assign res7 = (mag_q[MOD_BITS-1:0] == KEY_MODULUS) ? '0 : mag_q[MOD_BITS-1:0];

  // latch magnitude and sign, then fold high bits onto low bits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.value[31];
      mag_d  = req_i.value[31] ? (~req_i.value + 32'd1) : req_i.value;
    end else if (busy_q) begin
      if (mag_q[31:MOD_BITS] != '0) begin
        mag_d = (mag_q >> MOD_BITS) + {{(32-MOD_BITS){1'b0}}, mag_q[MOD_BITS-1:0]};
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
        rem_d  = neg_q ? (~{1'b0, res7} + 8'd1) : {1'b0, res7};
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== tb/sv/tb_xkrc_checker.sv =====
// checker for the xor keystream cipher: tracks the key, predicts and compares results
`timescale 1ns / 1ps

module tb_xkrc_checker #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xkrc_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          start_file_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [7:0]                    cipher_byte_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            rekeys_o
);
  import xkrc_pkg::*;

  localparam int MODULUS = int'(KEY_MODULUS);
  localparam int OFFSET  = int'(PROD_OFFSET);

  // shadow of the configuration and of the cipher state
  logic [LENW-1:0] key_len_q;
  logic [63:0]     key_reg_q [NUM_KEY_REGS];
  logic [7:0]      wkey_q [MAX_KEY_BYTES];
  logic [LENW-1:0] key_pos_q;

  // cipher bytes still owed by the block, oldest first
  logic [7:0] cipher_q [$];

  int err_cnt;
  int checked_cnt;
  int rekey_cnt;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    $display("[%0t] mismatch: %s, got %02h expected %02h", $realtime, what, got, want);
  endtask

  // clamp the key length register into 1..MAX_KEY_BYTES
  function automatic int active_len();
    int len;
    len = int'(key_len_q);
    if (len < 1) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    return len;
  endfunction

  // copy the little-endian key registers into the working key
  function automatic void load_key();
    for (int k = 0; k < MAX_KEY_BYTES; k++)
      wkey_q[k] = key_reg_q[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  // base^expo mod 127, remainders truncate toward zero
  function automatic int mod_pow127(input int base, input int expo);
    int acc;
    int sq;
    int e;
    acc = 1;
    sq  = base % MODULUS;
    e   = expo;
    while (e > 0) begin
      if (e & 1)
        acc = (acc * sq) % MODULUS;
      sq = (sq * sq) % MODULUS;
      e  = e >> 1;
    end
    return acc;
  endfunction

  // walk the key in order with a wrapping running product
  function automatic void rekey_key(input int len);
    int unsigned prod;
    int          b;
    int          r;
    prod = 1;
    for (int i = 0; i < len; i++) begin
      b    = int'($signed(wkey_q[i]));
      prod = prod * unsigned'(b + OFFSET);
      r    = mod_pow127(int'(prod), b);
      wkey_q[i] = r[7:0];
    end
  endfunction

  // expected cipher byte for one request, advancing the key position
  function automatic logic [7:0] predict_cipher(input logic [7:0] plain, input logic restart);
    int         len;
    logic [7:0] kb;
    len = active_len();
    if (restart)
      key_pos_q = '0;
    if (int'(key_pos_q) >= len) begin
      rekey_key(len);
      key_pos_q = '0;
      rekey_cnt++;
    end
    kb        = wkey_q[key_pos_q];
    key_pos_q = key_pos_q + LENW'(1);
    return plain ^ kb;
  endfunction

  // register write: any listed index reloads the working key
  function automatic void apply_cfg(input logic [CFG_IDXW-1:0] idx, input logic [63:0] wdata);
    bit hit;
    hit = 1'b1;
    case (cfg_idx_e'(idx))
      CFG_KEY_LEN: key_len_q = wdata[LENW-1:0];
      CFG_KEY0:    key_reg_q[0] = wdata;
      CFG_KEY1:    key_reg_q[1] = wdata;
      CFG_KEY2:    key_reg_q[2] = wdata;
      CFG_KEY3:    key_reg_q[3] = wdata;
      default:     hit = 1'b0;
    endcase
    if (hit)
      load_key();
  endfunction

  // watch both channels and the write port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [7:0] want;
    if (!rst_ni) begin
      key_len_q = LENW'(1);
      for (int r = 0; r < NUM_KEY_REGS; r++)
        key_reg_q[r] = '0;
      load_key();
      key_pos_q = '0;
      cipher_q.delete();
      err_cnt     = 0;
      checked_cnt = 0;
      rekey_cnt   = 0;
    end else begin
      if (cfg_we_i)
        apply_cfg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i)
        cipher_q.push_back(predict_cipher(data_byte_i, start_file_i));
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", cipher_byte_i, 8'h00);
        end else begin
          want = cipher_q.pop_front();
          checked_cnt++;
          if (cipher_byte_i !== want)
            report_mismatch("cipher_byte", cipher_byte_i, want);
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= cipher_q.size();
    checked_o <= checked_cnt;
    rekeys_o  <= rekey_cnt;
  end

endmodule

// ===== tb/sv/tb_xor_keystream_rekey_cipher.sv =====
// top of the cipher testbench: clock, reset, request traffic and verdict
`timescale 1ns / 1ps

module tb_xor_keystream_rekey_cipher;
  import xkrc_pkg::*;

  localparam int NUM_CFG_REGS = NUM_KEY_REGS + 1;
  localparam int RANDOM_ITEMS = 630;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int LIMIT_CYCLES = 600000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IDXW-1:0] cfg_idx;
  logic [63:0]         cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                start_file;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          cipher_byte;

  int errors;
  int pending;
  int checked;
  int rekeys;

  // traffic shaping shared with the receiver process
  logic stall_en;
  int   hold_req;
  bit   gaps_en;
  int   burst_left;
  int   sent_cnt;
  int   cfg_cnt;
  int   cycle_cnt;

  xor_keystream_rekey_cipher u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .start_file_i  (start_file),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cipher_byte_o (cipher_byte)
  );

  tb_xkrc_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .data_byte_i   (data_byte),
    .start_file_i  (start_file),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .cipher_byte_i (cipher_byte),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .rekeys_o      (rekeys)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAILURE");
    $finish;
  end

  // receiver: alternating stall and open runs, plus long hold-offs on request
  initial begin
    int  hold_seen;
    int  run_left;
    bit  stalled;
    hold_seen = 0;
    run_left  = 0;
    stalled   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        stalled  = 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stalled  = !stalled && stall_en;
        run_left = stalled ? $urandom_range(0, 4) : $urandom_range(0, 7);
        out_stall <= stalled;
      end
    end
  end

  // one request, with a random gap whenever a burst runs out
  task automatic send_req(input logic [7:0] d, input logic s);
    if (burst_left == 0) begin
      if (gaps_en) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    data_byte  <= d;
    start_file <= s;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDXW-1:0] idx, input logic [63:0] wdata);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_cnt++;
  endtask

  task automatic close_cfg();
    cfg_we <= 1'b0;
  endtask

  // key word with a bias toward sign and range boundary bytes
  function automatic logic [63:0] key_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       w[k*8 +: 8] = 8'h00;
          1:       w[k*8 +: 8] = 8'h01;
          2:       w[k*8 +: 8] = 8'h7F;
          3:       w[k*8 +: 8] = 8'h80;
          4:       w[k*8 +: 8] = 8'hFE;
          default: w[k*8 +: 8] = 8'hFF;
        endcase
      end
    end
    return w;
  endfunction

  // mostly short keys, sometimes the clamped and full-size ones
  function automatic logic [63:0] pick_key_len(input int phase);
    if (phase == 0) return 64'd32;
    if (phase == 1) return 64'd1;
    case ($urandom_range(0, 9))
      0:       return {$urandom, 26'd0, 6'($urandom_range(33, 63))};
      1:       return 64'd0;
      2:       return 64'd32;
      default: return 64'($urandom_range(1, 8));
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int target;
    int phase;
    int n;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    data_byte  <= '0;
    start_file <= 1'b0;
    stall_en   <= 1'b1;
    hold_req   <= 0;
    gaps_en    = 1'b1;
    burst_left = 0;
    sent_cnt   = 0;
    cfg_cnt    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: length one, all zero, so the second byte already rekeys
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'hA5, 1'b1);
    drain();

    // boundary key bytes, eight in use, restart in the middle
    write_cfg(CFG_KEY0, 64'h7E81_FE01_00FF_807F);
    write_cfg(CFG_KEY1, '1);
    write_cfg(CFG_KEY2, '0);
    write_cfg(CFG_KEY3, 64'h0123_4567_89AB_CDEF);
    write_cfg(CFG_KEY_LEN, 64'd8);
    close_cfg();
    for (int i = 0; i < 10; i++)
      send_req(8'($urandom_range(0, 255)), i == 6);
    drain();

    // length zero acts as one, and the position is already past it
    write_cfg(CFG_KEY_LEN, 64'd0);
    close_cfg();
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    drain();

    // write to an unused index leaves the key alone
    write_cfg(CFG_IDXW'($urandom_range(NUM_CFG_REGS, 2**CFG_IDXW - 1)), {$urandom, $urandom});
    close_cfg();
    send_req(8'h5A, 1'b0);
    drain();

    // oversized lengths clamp to the full key
    write_cfg(CFG_KEY_LEN, 64'd63);
    close_cfg();
    send_req(8'h80, 1'b1);
    send_req(8'h7F, 1'b0);
    send_req(8'h01, 1'b0);
    drain();
    write_cfg(CFG_KEY_LEN, 64'd33);
    close_cfg();
    send_req(8'hFE, 1'b0);
    send_req(8'h3C, 1'b1);

    // random phases, each with its own key setup and traffic shape
    target = sent_cnt + RANDOM_ITEMS;
    phase  = 0;
    while (sent_cnt < target) begin
      drain();
      for (int r = 0; r < NUM_KEY_REGS; r++)
        if (phase == 0 || $urandom_range(0, 1) == 1)
          write_cfg(CFG_IDXW'(int'(CFG_KEY0) + r), key_word());
      write_cfg(CFG_KEY_LEN, pick_key_len(phase));
      if ($urandom_range(0, 5) == 0)
        write_cfg(CFG_IDXW'($urandom_range(NUM_CFG_REGS, 2**CFG_IDXW - 1)),
                  {$urandom, $urandom});
      close_cfg();
      // every fourth phase runs flat out on both sides
      gaps_en = (phase % 4 != 3);
      stall_en <= (phase % 4 != 3);
      if (phase == 2 || phase == 9)
        hold_req <= hold_req + 1;
      n = $urandom_range(30, 70);
      for (int i = 0; i < n; i++)
        send_req(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests over %0d phases, %0d config writes", sent_cnt, phase, cfg_cnt);
    $display("checked %0d cipher bytes across %0d rekeys, %0d mismatches",
             checked, rekeys, errors);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== xor_keystream_rekey_cipher.f =====
hw/rtl/xkrc_pkg.sv
hw/rtl/xkrc_mod127.sv
hw/rtl/xor_keystream_rekey_cipher.sv
tb/sv/tb_xkrc_checker.sv
tb/sv/tb_xor_keystream_rekey_cipher.sv
